// ===== design/smr_pkg.sv =====
`timescale 1ns / 1ps
package smr_pkg;

    // Matrix geometry and word sizes.
    localparam int ELEM_W     = 32;
    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int DIM_W      = 4;
    localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DEPTH      = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_WALK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] waddr;
        logic              walk_init;
        logic              rd_en;
        logic              rd_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic             issue_ok;
    } t_sts;

endpackage

// ===== design/smr_if.sv =====
`timescale 1ns / 1ps
// Input word channel: one matrix element per word.
interface smr_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       element;
    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

// Output word channel: one spiral-ordered element per word.
interface smr_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       element_out;
    logic                     last;
    modport source (output valid, output element_out, output last, input ready);
    modport sink   (input valid, input element_out, input last, output ready);
endinterface

// Configuration write channel.
interface smr_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               index;
    logic [3:0]               data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/smr_ram.sv =====
`timescale 1ns / 1ps
module smr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/smr_ctrl.sv =====
`timescale 1ns / 1ps
module smr_ctrl
    import smr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_load_count, n_load_count;
    logic [CNT_W-1:0] r_emit_count, n_emit_count;
    logic [CNT_W-1:0] w_load_inc;
    logic [CNT_W-1:0] w_total_m1;

    assign w_load_inc = r_load_count + CNT_W'(1);
    assign w_total_m1 = i_sts.total - CNT_W'(1);

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_load_count <= '0;
            r_emit_count <= '0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_emit_count <= n_emit_count;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_load_count    = r_load_count;
        n_emit_count    = r_emit_count;
        o_in_ready      = 1'b0;
        o_cmd.wr_en     = 1'b0;
        o_cmd.waddr     = r_load_count[ADDR_W-1:0];
        o_cmd.walk_init = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_last   = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_en  = 1'b1;
                    n_load_count = w_load_inc;
                    // The word that fills the matrix starts the spiral walk.
                    if (w_load_inc >= i_sts.total) begin
                        n_load_count    = '0;
                        n_emit_count    = '0;
                        o_cmd.walk_init = 1'b1;
                        n_state         = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (i_sts.issue_ok) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_last = (r_emit_count == w_total_m1);
                    n_emit_count  = r_emit_count + CNT_W'(1);
                    if (r_emit_count == w_total_m1) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/smr_dp.sv =====
`timescale 1ns / 1ps
module smr_dp
    import smr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_element,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    smr_cfg_if.sink            i_cfg,
    smr_out_if.source          o_out
);

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    logic [DIM_W-1:0]  r_num_rows;
    logic [DIM_W-1:0]  r_num_cols;
    logic [DIM_W-1:0]  w_rows;
    logic [DIM_W-1:0]  w_cols;

    logic [POS_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_top, n_top;
    logic [POS_W-1:0]  r_bot, n_bot;
    logic [POS_W-1:0]  r_left, n_left;
    logic [POS_W-1:0]  r_right, n_right;
    t_dir              r_dir, n_dir;
    logic [ADDR_W-1:0] w_raddr;

    logic [ELEM_W-1:0] w_rdata;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_data;
    logic              r_out_last;
    logic              w_move;

    // Size registers; the write port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(MAX_ROWS);
            r_num_cols <= DIM_W'(MAX_COLS);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NUM_ROWS: r_num_rows <= i_cfg.data;
                REG_NUM_COLS: r_num_cols <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    // Sizes in use: zero counts as one, anything above the maximum as the maximum.
    assign w_rows = (r_num_rows == '0) ? DIM_W'(1) :
                    (r_num_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_num_rows;
    assign w_cols = (r_num_cols == '0) ? DIM_W'(1) :
                    (r_num_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_num_cols;

    // Element count, computed at full count width so that 8 x 8 does not wrap.
    assign o_sts.total = CNT_W'(w_rows) * CNT_W'(w_cols);

    // Read address of the current spiral position, row-major.
    assign w_raddr = ADDR_W'(r_row) * ADDR_W'(w_cols) + ADDR_W'(r_col);

    // Spiral walker: move along the edge, turn and shrink the bound at each corner.
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_top   = r_top;
        n_bot   = r_bot;
        n_left  = r_left;
        n_right = r_right;
        n_dir   = r_dir;
        if (i_cmd.walk_init) begin
            n_row   = '0;
            n_col   = '0;
            n_top   = '0;
            n_left  = '0;
            n_bot   = POS_W'(w_rows - DIM_W'(1));
            n_right = POS_W'(w_cols - DIM_W'(1));
            n_dir   = DIR_RIGHT;
        end else if (i_cmd.rd_en) begin
            unique case (r_dir)
                DIR_RIGHT: begin
                    if (r_col < r_right) begin
                        n_col = r_col + POS_W'(1);
                    end else begin
                        n_top = r_top + POS_W'(1);
                        n_row = r_row + POS_W'(1);
                        n_dir = DIR_DOWN;
                    end
                end
                DIR_DOWN: begin
                    if (r_row < r_bot) begin
                        n_row = r_row + POS_W'(1);
                    end else begin
                        n_right = r_right - POS_W'(1);
                        n_col   = r_col - POS_W'(1);
                        n_dir   = DIR_LEFT;
                    end
                end
                DIR_LEFT: begin
                    if (r_col > r_left) begin
                        n_col = r_col - POS_W'(1);
                    end else begin
                        n_bot = r_bot - POS_W'(1);
                        n_row = r_row - POS_W'(1);
                        n_dir = DIR_UP;
                    end
                end
                DIR_UP: begin
                    if (r_row > r_top) begin
                        n_row = r_row - POS_W'(1);
                    end else begin
                        n_left = r_left + POS_W'(1);
                        n_col  = r_col + POS_W'(1);
                        n_dir  = DIR_RIGHT;
                    end
                end
                default: begin
                    n_dir = DIR_RIGHT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_left  <= n_left;
        r_right <= n_right;
        r_dir   <= n_dir;
    end

    // Matrix store.
    smr_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.waddr),
        .i_wdata ($unsigned(i_element)),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Two-stage read pipeline: RAM read register, then output register.
    assign w_move         = r_rd_valid && (!r_out_valid || o_out.ready);
    assign o_sts.issue_ok = !r_rd_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_valid <= 1'b1;
            end else if (w_move) begin
                r_rd_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_last <= i_cmd.rd_last;
        end
        if (w_move) begin
            r_out_data <= w_rdata;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.element_out = signed'(r_out_data);
    assign o_out.last        = r_out_last;

endmodule

// ===== design/spiral_order_matrix_reader_top.sv =====
`timescale 1ns / 1ps
// Spiral order matrix reader. Load a num_rows x num_cols matrix (each size 1 to 8,
// zero is taken as one and larger values as eight) one element per input word in
// row-major order, one word per cycle. The word that completes the matrix starts
// the readout: every element comes out in clockwise spiral order, one word per
// cycle while the output is taken, set by the single read port of the matrix
// store; the final word carries last. The first result passes through the RAM read
// register and the output register, and a new load is accepted as soon as the last
// read has been issued. Write the size registers only while the block is idle.
// The store is not cleared: only entries loaded since reset may be read back.
module spiral_order_matrix_reader_top
    import smr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    smr_in_if.sink     i_in,
    smr_cfg_if.sink    i_cfg,
    smr_out_if.source  o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    smr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    smr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_element (i_in.element),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

    // A store write happens exactly when an input word is accepted.
    a_wr_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en == (i_in.valid && i_in.ready))
        else $error("store write does not match input accept");

    // Loading and readout never share a cycle.
    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_en && w_cmd.rd_en))
        else $error("store write and read in the same cycle");

    // A read is issued only when the pipeline has room for its data.
    a_rd_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> w_sts.issue_ok)
        else $error("read issued into a full pipeline");

    // After the last read of a run the controller is back to loading.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.rd_en && w_cmd.rd_last) |=> (!w_cmd.rd_en && i_in.ready))
        else $error("walk continued past the last element");

endmodule
